>>> src/ilat_pkg.sv
// Shared types and constants for the Ising lattice energy unit.
// No dependencies; imported by ising_lattice_energy_unit and ilat_acc.
`default_nettype none

package ilat_pkg;

  // Lattice geometry
  localparam int LATTICE_SIDE = 64;
  localparam int CELLS        = LATTICE_SIDE * LATTICE_SIDE;
  localparam int ROW_W        = $clog2(LATTICE_SIDE);

  // Port field widths
  localparam int CMD_W    = 1;
  localparam int COORD_W  = 6;
  localparam int FIELD_W  = 16;
  localparam int ENERGY_W = 29;
  localparam int MAG_W    = 14;

  // Accumulator widths: magnetisation spans +-CELLS, bond sum +-4*CELLS
  localparam int MAG_ACC_W  = $clog2(CELLS) + 2;
  localparam int BOND_W     = $clog2(CELLS) + 4;
  localparam int PROD_W     = FIELD_W + MAG_ACC_W;
  localparam int FRAC_BITS  = 8;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_FIELD_STRENGTH = 3'd0;

  // Input command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_MOD,
    ST_LD_PREV,
    ST_LD_ROW,
    ST_SITES,
    ST_MUL,
    ST_SUM
  } state_t;

  // Control from the sequencer to the site accumulator
  typedef struct packed {
    logic clear;
    logic site_en;
    logic mul_en;
    logic s_self;
    logic s_right;
    logic s_up;
  } acc_ctl_t;

endpackage

`default_nettype wire

>>> src/ising_lattice_energy_unit.sv
// Ising lattice energy unit: holds a LATTICE_SIDE x LATTICE_SIDE spin
// lattice on a torus, one RAM row per lattice row, with a sequencer that
// walks every site through one shared accumulator. After reset a clearing
// pass sets every spin to +1, row by row; no item is taken during it. A
// spin write reads its row, then writes back the modified row. A compute
// item walks one site per cycle through the accumulator, pausing for one
// row load per lattice row from the single RAM read port. The unit takes
// new items while a result waits in the output register. The field H is
// written over the APB port at address 0 and should be changed only while
// the unit is idle.
// Depends on ilat_pkg, ilat_ram and ilat_acc.
`default_nettype none

module ising_lattice_energy_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // Input channel
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [ilat_pkg::CMD_W-1:0]            in_command,
  input  wire logic [ilat_pkg::COORD_W-1:0]          in_row,
  input  wire logic [ilat_pkg::COORD_W-1:0]          in_col,
  input  wire logic                                  in_spin_up,
  // Result channel
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [ilat_pkg::ENERGY_W-1:0]       out_energy_q8,
  output logic signed [ilat_pkg::MAG_W-1:0]          out_magnetisation,
  // Configuration port
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [ilat_pkg::PADDR_W-1:0]          paddr,
  input  wire logic [ilat_pkg::PDATA_W-1:0]          pwdata,
  output logic      [ilat_pkg::PDATA_W-1:0]          prdata,
  output logic                                       pready
);
  import ilat_pkg::*;

  localparam logic [ROW_W-1:0] LAST_IDX = ROW_W'(LATTICE_SIDE - 1);

  state_t state_r, state_nxt;

  logic signed [FIELD_W-1:0]   field_r;
  logic [ROW_W-1:0]            row_r;
  logic [ROW_W-1:0]            col_r;
  logic [ROW_W-1:0]            col_rt;
  logic [ROW_W-1:0]            wr_row_r;
  logic [ROW_W-1:0]            wr_col_r;
  logic                        wr_spin_r;
  logic [LATTICE_SIDE-1:0]     cur_row_r;
  logic [LATTICE_SIDE-1:0]     prev_row_r;
  logic [LATTICE_SIDE-1:0]     row_mod;

  logic                        ram_we;
  logic [ROW_W-1:0]            ram_waddr;
  logic [LATTICE_SIDE-1:0]     ram_wdata;
  logic [ROW_W-1:0]            ram_raddr;
  logic [LATTICE_SIDE-1:0]     ram_rdata;

  acc_ctl_t                    acc_ctl;
  logic signed [ENERGY_W-1:0]  acc_energy;
  logic signed [MAG_W-1:0]     acc_mag;

  logic                        in_beat;
  logic                        is_compute;
  logic                        wr_in_range;
  logic                        out_load;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [ENERGY_W-1:0]  out_energy_r;
  logic signed [MAG_W-1:0]     out_mag_r;

  // APB register access
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_FIELD_STRENGTH) ?
                  PDATA_W'($unsigned(field_r)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == ADDR_FIELD_STRENGTH) begin
      field_r <= FIELD_W'(pwdata);
    end
  end

  // Input decode
  assign in_beat     = in_valid && in_ready;
  assign is_compute  = (cmd_t'(in_command) == CMD_COMPUTE);
  assign wr_in_range = (int'(in_row) < LATTICE_SIDE) && (int'(in_col) < LATTICE_SIDE);
  assign col_rt      = (col_r == LAST_IDX) ? '0 : col_r + ROW_W'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (row_r == LAST_IDX) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_beat) begin
          if (is_compute)       state_nxt = ST_LD_PREV;
          else if (wr_in_range) state_nxt = ST_WR_MOD;
        end
      end
      ST_WR_MOD:  state_nxt = ST_IDLE;
      ST_LD_PREV: state_nxt = ST_LD_ROW;
      ST_LD_ROW:  state_nxt = ST_SITES;
      ST_SITES: begin
        if (col_r == LAST_IDX) begin
          state_nxt = (row_r == LAST_IDX) ? ST_MUL : ST_LD_ROW;
        end
      end
      ST_MUL: state_nxt = ST_SUM;
      ST_SUM: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Splice the written spin into the row read back
  always_comb begin
    row_mod           = ram_rdata;
    row_mod[wr_col_r] = wr_spin_r;
  end

  // Sequencer outputs
  always_comb begin
    in_ready        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = row_r;
    ram_wdata       = row_mod;
    ram_raddr       = row_r + ROW_W'(1);
    out_load        = 1'b0;
    acc_ctl         = '0;
    acc_ctl.s_self  = cur_row_r[col_r];
    acc_ctl.s_right = cur_row_r[col_rt];
    acc_ctl.s_up    = prev_row_r[col_r];
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        ram_raddr     = is_compute ? LAST_IDX : ROW_W'(in_row);
        acc_ctl.clear = in_beat && is_compute;
      end
      ST_WR_MOD: begin
        ram_we    = 1'b1;
        ram_waddr = wr_row_r;
      end
      ST_LD_PREV: begin
        ram_raddr = '0;
      end
      ST_LD_ROW: begin
      end
      ST_SITES: begin
        acc_ctl.site_en = 1'b1;
      end
      ST_MUL: begin
        acc_ctl.mul_en = 1'b1;
      end
      ST_SUM: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  // State and row counter; the counter also drives the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      priority if (state_r == ST_CLEAR) begin
        row_r <= (row_r == LAST_IDX) ? '0 : row_r + ROW_W'(1);
      end else if (state_r == ST_LD_PREV) begin
        row_r <= '0;
      end else if (state_r == ST_SITES && col_r == LAST_IDX) begin
        row_r <= row_r + ROW_W'(1);
      end
    end
  end

  // Column walk and row buffers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (state_r == ST_LD_ROW) begin
      col_r <= '0;
    end else if (state_r == ST_SITES) begin
      col_r <= col_rt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LD_PREV) begin
      prev_row_r <= ram_rdata;
    end else if (state_r == ST_SITES && col_r == LAST_IDX) begin
      prev_row_r <= cur_row_r;
    end
    if (state_r == ST_LD_ROW) begin
      cur_row_r <= ram_rdata;
    end
  end

  // Hold the coordinates of a spin write
  always_ff @(posedge clk) begin
    if (in_beat) begin
      wr_row_r  <= ROW_W'(in_row);
      wr_col_r  <= ROW_W'(in_col);
      wr_spin_r <= in_spin_up;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)                      out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_energy_r <= acc_energy;
      out_mag_r    <= acc_mag;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_energy_q8     = out_energy_r;
  assign out_magnetisation = out_mag_r;

  // Spin store, one lattice row per word
  ilat_ram #(
    .WIDTH (LATTICE_SIDE),
    .DEPTH (LATTICE_SIDE)
  ) u_spin_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared site accumulator
  ilat_acc u_acc (
    .clk            (clk),
    .ctl            (acc_ctl),
    .field_strength (field_r),
    .energy         (acc_energy),
    .magnetisation  (acc_mag)
  );

endmodule

`default_nettype wire

>>> src/ilat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ilat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/ilat_acc.sv
// Site accumulator: bond and magnetisation sums, field product, energy.
// Depends on ilat_pkg.
`default_nettype none

module ilat_acc (
  input  wire logic                                clk,
  input  wire ilat_pkg::acc_ctl_t                  ctl,
  input  wire logic signed [ilat_pkg::FIELD_W-1:0] field_strength,
  output logic signed [ilat_pkg::ENERGY_W-1:0]     energy,
  output logic signed [ilat_pkg::MAG_W-1:0]        magnetisation
);
  import ilat_pkg::*;

  localparam logic signed [MAG_ACC_W-1:0] MAG_ONE  = MAG_ACC_W'(1);
  localparam logic signed [BOND_W-1:0]    BOND_FOUR = BOND_W'(4);

  logic signed [BOND_W-1:0]    bond_r, bond_nxt;
  logic signed [MAG_ACC_W-1:0] mag_r, mag_nxt;
  logic signed [PROD_W-1:0]    prod_r;
  logic                        agree_h, agree_v;
  logic signed [ENERGY_W-1:0]  bond_scaled;

  // Each site adds twice its right and upper bonds: +4, 0 or -4
  always_comb begin
    agree_h  = ctl.s_self ~^ ctl.s_right;
    agree_v  = ctl.s_self ~^ ctl.s_up;
    bond_nxt = bond_r;
    mag_nxt  = mag_r;
    if (ctl.clear) begin
      bond_nxt = '0;
      mag_nxt  = '0;
    end else if (ctl.site_en) begin
      unique case ({agree_h, agree_v})
        2'b11:   bond_nxt = bond_r + BOND_FOUR;
        2'b00:   bond_nxt = bond_r - BOND_FOUR;
        default: bond_nxt = bond_r;
      endcase
      mag_nxt = ctl.s_self ? mag_r + MAG_ONE : mag_r - MAG_ONE;
    end
  end

  always_ff @(posedge clk) begin
    bond_r <= bond_nxt;
    mag_r  <= mag_nxt;
  end

  // Register the field times magnetisation product
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= field_strength * mag_r;
    end
  end

  // Energy = -(bonds << 8) - H * mag, wrapped to the output width
  assign bond_scaled   = ENERGY_W'(bond_r) <<< FRAC_BITS;
  assign energy        = -bond_scaled - ENERGY_W'(prod_r);
  assign magnetisation = MAG_W'(mag_r);

endmodule

`default_nettype wire
